### rtl/point_gridder_2d_defines.svh
// Assertion macros for the point gridder.
`ifndef POINT_GRIDDER_2D_DEFINES_SVH
`define POINT_GRIDDER_2D_DEFINES_SVH
`ifndef ASSERT_OFF
`define PG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PG_ASSERT(lbl, expr, msg)
`define PG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pgrid_pkg.sv
`timescale 1ns / 1ps
package pgrid_pkg;

  localparam int MaxCellsX   = 64;
  localparam int MaxCellsY   = 64;
  localparam int StoreDepth  = 4096;
  localparam int AddrW       = 12;
  localparam int SumW        = 48;
  localparam int CountW      = 24;
  localparam int DivSteps    = 48;

  // Register indexes on the configuration channel
  typedef enum logic [2:0] {
    REG_X_MIN     = 3'd0,
    REG_X_MAX     = 3'd1,
    REG_Y_MIN     = 3'd2,
    REG_Y_MAX     = 3'd3,
    REG_X_SCALE   = 3'd4,
    REG_Y_SCALE   = 3'd5,
    REG_CELLS_Y   = 3'd6,
    REG_NORMALIZE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] sample_value;
    logic [11:0]        read_cell;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               accepted;
    logic [11:0]        cell_index;
    logic signed [47:0] cell_value;
    logic [23:0]        cell_hits;
  } out_item_t;

endpackage

### rtl/point_gridder_2d.sv
`timescale 1ns / 1ps
`include "point_gridder_2d_defines.svh"
// Point gridder: after reset the block clears its 4096-entry sum and count
// memories, one entry a cycle, and holds busy high until the clear is done.
// A transaction is taken when start is high and busy is low; busy then stays
// high until its result shows on out_data for one cycle with out_valid high.
// The receiver cannot stall, so sample out_data whenever out_valid is high.
// A point goes through offset, multiply, rounding, cell address and memory
// read, then write-back. A cell read returns the sum, or the mean when
// normalize is set: the division runs one quotient bit a cycle over 48 bits.
// Configuration writes are always ready; write them only while busy is low.
module point_gridder_2d #(
  parameter int MAX_CELLS_X = pgrid_pkg::MaxCellsX,
  parameter int MAX_CELLS_Y = pgrid_pkg::MaxCellsY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pgrid_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output pgrid_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int XI_W   = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int CELL_W = XI_W + 14;
  localparam int AW     = pgrid_pkg::AddrW;
  localparam int SW     = pgrid_pkg::SumW;
  localparam int CW     = pgrid_pkg::CountW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_CELL  = 8'b0001_0000,
    S_UPD   = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_DIV   = 8'b1000_0000
  } state_t;

  // Configuration registers
  logic signed [31:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [31:0]        x_scale_r, y_scale_r;
  logic [6:0]         cells_y_r;
  logic               normalize_r;

  // Control and datapath registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               rej_r, rej_nxt;
  logic [31:0]        off_x_r, off_x_nxt, off_y_r, off_y_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [63:0]        px_r, px_nxt, py_r, py_nxt;
  logic [XI_W-1:0]    xi_r, xi_nxt;
  logic [6:0]         yi_r, yi_nxt;
  logic [6:0]         stride_r, stride_nxt;
  logic [AW-1:0]      cell_r, cell_nxt;
  logic [SW-1:0]      mag_r, mag_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]      hits_r, hits_nxt;
  logic               neg_r, neg_nxt;
  logic [5:0]         div_cnt_r, div_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  pgrid_pkg::out_item_t out_data_r, out_data_nxt;

  // Memory signals
  logic [SW-1:0] sum_mem [pgrid_pkg::StoreDepth];
  logic [CW-1:0] cnt_mem [pgrid_pkg::StoreDepth];
  logic [SW-1:0] sum_q;
  logic [CW-1:0] cnt_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wsum;
  logic [CW-1:0] mem_wcnt;

  // Combinational helpers
  logic              in_range;
  logic [31:0]       qx, qy, rx, ry;
  logic              upx, upy;
  logic [32:0]       xi_full, yi_full;
  logic [6:0]        stride_c;
  logic [CELL_W-1:0] cell_full;
  logic signed [SW:0] sum_ext;
  logic [SW-1:0]     sum_sat;
  logic [CW-1:0]     cnt_inc;
  logic [CW:0]       trial;
  logic              ge;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r     <= '0;
      x_max_r     <= '0;
      y_min_r     <= '0;
      y_max_r     <= '0;
      x_scale_r   <= '0;
      y_scale_r   <= '0;
      cells_y_r   <= 7'd64;
      normalize_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pgrid_pkg::reg_idx_t'(cfg_index))
        pgrid_pkg::REG_X_MIN:     x_min_r     <= cfg_wdata;
        pgrid_pkg::REG_X_MAX:     x_max_r     <= cfg_wdata;
        pgrid_pkg::REG_Y_MIN:     y_min_r     <= cfg_wdata;
        pgrid_pkg::REG_Y_MAX:     y_max_r     <= cfg_wdata;
        pgrid_pkg::REG_X_SCALE:   x_scale_r   <= cfg_wdata;
        pgrid_pkg::REG_Y_SCALE:   y_scale_r   <= cfg_wdata;
        pgrid_pkg::REG_CELLS_Y:   cells_y_r   <= cfg_wdata[6:0];
        pgrid_pkg::REG_NORMALIZE: normalize_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Range check and effective row stride
  always_comb begin
    in_range = (in_data.x_coord >= x_min_r) && (in_data.x_coord <= x_max_r) &&
               (in_data.y_coord >= y_min_r) && (in_data.y_coord <= y_max_r);
    if (cells_y_r == 7'd0) begin
      stride_c = 7'd1;
    end else if (int'(cells_y_r) > MAX_CELLS_Y) begin
      stride_c = 7'(MAX_CELLS_Y);
    end else begin
      stride_c = cells_y_r;
    end
  end

  // Round half to even to get the axis indexes
  always_comb begin
    qx = px_r[63:32];
    rx = px_r[31:0];
    qy = py_r[63:32];
    ry = py_r[31:0];
    upx = (rx > 32'h8000_0000) || ((rx == 32'h8000_0000) && qx[0]);
    upy = (ry > 32'h8000_0000) || ((ry == 32'h8000_0000) && qy[0]);
    xi_full = {1'b0, qx} + 33'(upx);
    yi_full = {1'b0, qy} + 33'(upy);
  end

  // Cell address, saturating update and divider step
  always_comb begin
    cell_full = CELL_W'(xi_r) * CELL_W'(stride_r) + CELL_W'(yi_r);
    sum_ext   = $signed({sum_q[SW-1], sum_q}) + (SW+1)'(val_r);
    if (sum_ext > $signed({2'b00, {(SW-1){1'b1}}})) begin
      sum_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (sum_ext < $signed({2'b11, {(SW-1){1'b0}}})) begin
      sum_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
    cnt_inc = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + CW'(1);
    trial   = {rem_r, mag_r[SW-1]};
    ge      = (trial >= {1'b0, hits_r});
  end

  // Sequence one transaction at a time
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    rej_nxt       = rej_r;
    off_x_nxt     = off_x_r;
    off_y_nxt     = off_y_r;
    val_nxt       = val_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    xi_nxt        = xi_r;
    yi_nxt        = yi_r;
    stride_nxt    = stride_r;
    cell_nxt      = cell_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    hits_nxt      = hits_r;
    neg_nxt       = neg_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cell_r;
    mem_wsum      = sum_sat;
    mem_wcnt      = cnt_inc;
    mem_raddr     = in_data.read_cell;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wsum     = '0;
        mem_wcnt     = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cell_nxt  = in_data.read_cell;
          off_x_nxt = 32'(in_data.x_coord - x_min_r);
          off_y_nxt = 32'(in_data.y_coord - y_min_r);
          val_nxt   = in_data.sample_value;
          rej_nxt   = !in_range;
          state_nxt = in_data.req_type ? S_RD : S_MUL;
        end
      end
      S_MUL: begin
        px_nxt    = 64'(off_x_r) * 64'(x_scale_r);
        py_nxt    = 64'(off_y_r) * 64'(y_scale_r);
        state_nxt = S_IDX;
      end
      S_IDX: begin
        stride_nxt = stride_c;
        xi_nxt     = xi_full[XI_W-1:0];
        yi_nxt     = yi_full[6:0];
        if ((xi_full >= 33'(MAX_CELLS_X)) || (yi_full >= 33'(stride_c))) begin
          rej_nxt = 1'b1;
        end
        state_nxt = S_CELL;
      end
      S_CELL: begin
        mem_raddr = cell_full[AW-1:0];
        cell_nxt  = cell_full[AW-1:0];
        if (cell_full >= CELL_W'(pgrid_pkg::StoreDepth)) begin
          rej_nxt = 1'b1;
        end
        state_nxt = S_UPD;
      end
      S_UPD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (!rej_r) begin
          mem_we                  = 1'b1;
          out_data_nxt.accepted   = 1'b1;
          out_data_nxt.cell_index = cell_r;
          out_data_nxt.cell_value = sum_sat;
          out_data_nxt.cell_hits  = cnt_inc;
        end
        state_nxt = S_IDLE;
      end
      S_RD: begin
        hits_nxt = cnt_q;
        if (normalize_r && (cnt_q != '0)) begin
          neg_nxt     = sum_q[SW-1];
          mag_nxt     = sum_q[SW-1] ? (SW'(0) - sum_q) : sum_q;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.result_kind = 1'b1;
          out_data_nxt.cell_index  = cell_r;
          out_data_nxt.cell_value  = sum_q;
          out_data_nxt.cell_hits   = cnt_q;
          state_nxt                = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt     = ge ? CW'(trial - {1'b0, hits_r}) : trial[CW-1:0];
        mag_nxt     = {mag_r[SW-2:0], ge};
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'(pgrid_pkg::DivSteps - 1)) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.result_kind = 1'b1;
          out_data_nxt.cell_index  = cell_r;
          out_data_nxt.cell_value  = neg_r ? (SW'(0) - {mag_r[SW-2:0], ge})
                                           : {mag_r[SW-2:0], ge};
          out_data_nxt.cell_hits   = hits_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    rej_r      <= rej_nxt;
    off_x_r    <= off_x_nxt;
    off_y_r    <= off_y_nxt;
    val_r      <= val_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    xi_r       <= xi_nxt;
    yi_r       <= yi_nxt;
    stride_r   <= stride_nxt;
    cell_r     <= cell_nxt;
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    hits_r     <= hits_nxt;
    neg_r      <= neg_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sum and count memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wsum;
      cnt_mem[mem_waddr] <= mem_wcnt;
    end
    sum_q <= sum_mem[mem_raddr];
    cnt_q <= cnt_mem[mem_raddr];
  end

  `PG_ASSERT(a_result_when_idle, !out_valid_r || (state_r == S_IDLE), "result outside idle")
  `PG_ASSERT_NEXT(a_start_leaves_idle, start && !busy, state_r != S_IDLE, "start not taken")
  `PG_ASSERT(a_no_result_in_clear, !((state_r == S_CLEAR) && out_valid_r), "result in clear")
  `PG_ASSERT_NEXT(a_div_ends, (state_r == S_DIV) && (div_cnt_r == 6'(pgrid_pkg::DivSteps - 1)), out_valid_r && (state_r == S_IDLE), "divide did not finish")

endmodule

### tb/point_gridder_2d_tb.sv
`timescale 1ns / 1ps
module point_gridder_2d_tb;

  localparam longint SumHi = 64'sd140737488355327;
  localparam longint SumLo = -64'sd140737488355328;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  pgrid_pkg::in_item_t  in_data;
  logic      out_valid;
  pgrid_pkg::out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  point_gridder_2d u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the grid: limits, scales, stride and the two cell stores
  logic signed [31:0] x_lo, x_hi, y_lo, y_hi;
  logic [31:0]        x_scl, y_scl;
  logic [6:0]         stride_reg;
  logic               norm_on;
  logic signed [47:0] cell_sum [pgrid_pkg::StoreDepth];
  logic [23:0]        cell_count [pgrid_pkg::StoreDepth];

  pgrid_pkg::in_item_t  point_feed [$];
  pgrid_pkg::out_item_t due_results [$];
  int        cfg_writes;
  int        gap_left;
  logic      took;
  logic      failed;

  // Round half to even of offset * scale in Q32.32
  function automatic longint axis_bin(logic [31:0] offset, logic [31:0] scale);
    logic [63:0] prod;
    logic [63:0] q;
    prod = {32'd0, offset} * {32'd0, scale};
    q = {32'd0, prod[63:32]};
    if (prod[31:0] > 32'h8000_0000 || (prod[31:0] == 32'h8000_0000 && q[0]))
      q = q + 64'd1;
    return longint'(q);
  endfunction

  // Work out the result of one transaction and update the mirrored stores
  function automatic pgrid_pkg::out_item_t grid_predict(pgrid_pkg::in_item_t it);
    pgrid_pkg::out_item_t r;
    longint    s, c, xi, yi, stride, cell_no;
    r = '0;
    r.result_kind = it.req_type;
    if (it.req_type) begin
      s = cell_sum[it.read_cell];
      c = cell_count[it.read_cell];
      if (norm_on && c != 0) s = s / c;
      r.cell_index = it.read_cell;
      r.cell_value = s[47:0];
      r.cell_hits  = c[23:0];
      return r;
    end
    stride = (stride_reg == 0) ? 1 : longint'(stride_reg);
    if (stride > pgrid_pkg::MaxCellsY) stride = pgrid_pkg::MaxCellsY;
    if (it.x_coord < x_lo || it.x_coord > x_hi || it.y_coord < y_lo || it.y_coord > y_hi)
      return r;
    xi = axis_bin(it.x_coord - x_lo, x_scl);
    yi = axis_bin(it.y_coord - y_lo, y_scl);
    if (xi >= pgrid_pkg::MaxCellsX || yi >= stride) return r;
    cell_no = xi * stride + yi;
    if (cell_no >= pgrid_pkg::StoreDepth) return r;
    s = longint'(cell_sum[cell_no[11:0]]) + longint'(it.sample_value);
    if (s > SumHi) s = SumHi;
    if (s < SumLo) s = SumLo;
    cell_sum[cell_no[11:0]] = s[47:0];
    if (cell_count[cell_no[11:0]] != 24'hFF_FFFF)
      cell_count[cell_no[11:0]] = cell_count[cell_no[11:0]] + 24'd1;
    r.accepted   = 1'b1;
    r.cell_index = cell_no[11:0];
    r.cell_value = s[47:0];
    r.cell_hits  = cell_count[cell_no[11:0]];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: present queued transactions with a random gap between them
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(start && !took)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left = gap_left - 1;
        end else if (point_feed.size() > 0) begin
          in_data <= point_feed.pop_front();
          start   <= 1'b1;
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on accept, track register writes, check results
  always @(posedge clk) begin
    pgrid_pkg::out_item_t want;
    if (rst_n) begin
      took = start && !busy;
      if (took) due_results.push_back(grid_predict(in_data));
      if (cfg_valid && cfg_ready) begin
        cfg_writes = cfg_writes + 1;
        case (pgrid_pkg::reg_idx_t'(cfg_index))
          pgrid_pkg::REG_X_MIN:     x_lo = cfg_wdata;
          pgrid_pkg::REG_X_MAX:     x_hi = cfg_wdata;
          pgrid_pkg::REG_Y_MIN:     y_lo = cfg_wdata;
          pgrid_pkg::REG_Y_MAX:     y_hi = cfg_wdata;
          pgrid_pkg::REG_X_SCALE:   x_scl = cfg_wdata;
          pgrid_pkg::REG_Y_SCALE:   y_scl = cfg_wdata;
          pgrid_pkg::REG_CELLS_Y:   stride_reg = cfg_wdata[6:0];
          pgrid_pkg::REG_NORMALIZE: norm_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result with no transaction pending");
          failed = 1'b1;
        end else begin
          want = due_results.pop_front();
          if (want.result_kind !== out_data.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_data.result_kind);
            failed = 1'b1;
          end
          if (want.accepted !== out_data.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
            failed = 1'b1;
          end
          if (want.cell_index !== out_data.cell_index) begin
            $error("cell_index: expected %0d, got %0d", want.cell_index,
                   out_data.cell_index);
            failed = 1'b1;
          end
          if (want.cell_value !== out_data.cell_value) begin
            $error("cell_value: expected %0d, got %0d", want.cell_value,
                   out_data.cell_value);
            failed = 1'b1;
          end
          if (want.cell_hits !== out_data.cell_hits) begin
            $error("cell_hits: expected %0d, got %0d", want.cell_hits,
                   out_data.cell_hits);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] v);
    pgrid_pkg::in_item_t it;
    it = '0;
    it.req_type     = 1'b0;
    it.x_coord      = x;
    it.y_coord      = y;
    it.sample_value = v;
    it.read_cell    = 12'($urandom);
    point_feed.push_back(it);
  endtask

  task automatic add_read(logic [11:0] cell_no);
    pgrid_pkg::in_item_t it;
    it = '0;
    it.req_type     = 1'b1;
    it.x_coord      = $urandom;
    it.y_coord      = $urandom;
    it.sample_value = $urandom;
    it.read_cell    = cell_no;
    point_feed.push_back(it);
  endtask

  // Hold until every transaction is taken and answered, then let the block settle
  task automatic drain();
    while (point_feed.size() > 0 || start || busy || due_results.size() > 0)
      @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(pgrid_pkg::reg_idx_t idx, logic [31:0] data);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_grid(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                          logic [31:0] yh, logic [31:0] xs, logic [31:0] ys,
                          logic [6:0] cy, logic nrm);
    write_reg(pgrid_pkg::REG_X_MIN, xl);
    write_reg(pgrid_pkg::REG_X_MAX, xh);
    write_reg(pgrid_pkg::REG_Y_MIN, yl);
    write_reg(pgrid_pkg::REG_Y_MAX, yh);
    write_reg(pgrid_pkg::REG_X_SCALE, xs);
    write_reg(pgrid_pkg::REG_Y_SCALE, ys);
    write_reg(pgrid_pkg::REG_CELLS_Y, {25'd0, cy});
    write_reg(pgrid_pkg::REG_NORMALIZE, {31'd0, nrm});
  endtask

  // Coordinate mostly inside [lo, hi], sometimes just outside or anywhere
  function automatic logic [31:0] pick_coord(logic signed [31:0] lo,
                                             logic signed [31:0] hi, bit ties);
    logic [32:0] span;
    logic [31:0] off;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom;
    if (pick == 1) return lo - 1;
    if (pick == 2) return hi + 1;
    if (pick == 3) return lo;
    if (pick == 4) return hi;
    span = {hi[31], hi} - {lo[31], lo};
    if (span[32]) return $urandom;
    off = (span[31:0] == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, span[31:0]);
    if (ties && $urandom_range(0, 1)) off = {off[31:16], 16'h8000};
    return lo + off;
  endfunction

  initial begin
    int       phase, n, k, cy, span_cells;
    logic [31:0] xl, xh, yl, yh, xs, ys;
    logic [11:0] hit_cells [$];
    bit          ties;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cfg_writes = 0;
    gap_left = 0;
    took = 1'b0;
    failed = 1'b0;
    x_lo = 0; x_hi = 0; y_lo = 0; y_hi = 0;
    x_scl = 0; y_scl = 0;
    stride_reg = 7'd64;
    norm_on = 1'b1;
    for (int i = 0; i < pgrid_pkg::StoreDepth; i++) begin
      cell_sum[i] = '0;
      cell_count[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset limits: only the origin is in range, zero scale lands on cell 0
    add_point(32'd0, 32'd0, 32'h7FFF_FFFF);
    add_point(32'd0, 32'd0, 32'h8000_0000);
    add_point(32'd0, 32'd0, 32'd3);
    add_point(32'd1, 32'd0, 32'd5);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd5);
    add_read(12'd0);
    add_read(12'd4095);
    drain();

    // Unit-step grid: ties at half a cell, edges, one lsb outside
    set_grid(32'd0, 32'd63 << 16, 32'd0, 32'd15 << 16, 32'h0001_0000,
             32'h0001_0000, 7'd16, 1'b1);
    add_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    add_point(32'h0001_8000, 32'h0002_8000, 32'hFFFF_0000);
    add_point(32'd63 << 16, 32'd15 << 16, 32'd7);
    add_point((32'd63 << 16) + 1, 32'd0, 32'd7);
    add_point(32'hFFFF_FFFF, 32'd0, 32'd7);
    add_point(32'd0, 32'h000F_8000, 32'd9);
    add_point(32'd0, 32'd0, 32'hFFFF_FFF9);
    add_read(12'd0);
    add_read(12'd1023);
    drain();

    // Random phases over several grid shapes
    for (phase = 0; phase < 10; phase++) begin
      ties = 0;
      case (phase % 5)
        0: begin
          cy = $urandom_range(1, 64);
          xl = $urandom_range(0, 255) - 128;
          xl = xl << 16;
          xh = xl + (32'd63 << 16);
          yl = -(32'd4 << 16);
          yh = yl + ((cy - 1) << 16);
          xs = 32'h0001_0000;
          ys = 32'h0001_0000;
          ties = 1;
        end
        1: begin
          cy = (phase < 5) ? 0 : 127;
          xl = $urandom;
          xh = xl + $urandom_range(1, 32'h0100_0000);
          if ($signed(xh) < $signed(xl)) xh = 32'h7FFF_FFFF;
          yl = $urandom;
          yh = yl + $urandom_range(1, 32'h0100_0000);
          if ($signed(yh) < $signed(yl)) yh = 32'h7FFF_FFFF;
          span_cells = (cy == 0) ? 1 : 64;
          xs = 32'((64'd63 << 32) / (64'(xh - xl)));
          ys = 32'((64'(span_cells - 1) << 32) / (64'(yh - yl)));
        end
        2: begin
          cy = $urandom_range(1, 64);
          xl = 32'h8000_0000;
          xh = 32'h7FFF_FFFF;
          yl = 32'h8000_0000;
          yh = 32'h7FFF_FFFF;
          xs = (phase < 5) ? 32'd0 : 32'd60;
          ys = (phase < 5) ? 32'hFFFF_FFFF : 32'd1;
        end
        3: begin
          cy = 64;
          xl = 32'd10 << 16;
          xh = 32'd2 << 16;
          yl = 32'd0;
          yh = 32'd63 << 16;
          xs = 32'h0001_0000;
          ys = 32'h0001_0000;
        end
        default: begin
          cy = $urandom_range(1, 64);
          xl = -(32'd10 << 16);
          xh = 32'd10 << 16;
          yl = -(32'd5 << 16);
          yh = 32'd5 << 16;
          xs = 32'((64'd63 << 32) / (64'd20 << 16));
          ys = 32'((64'(cy - 1) << 32) / (64'd10 << 16));
        end
      endcase
      set_grid(xl, xh, yl, yh, xs, ys, cy[6:0], phase[0]);
      hit_cells.delete();
      for (n = 0; n < 125; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          if (hit_cells.size() > 0 && $urandom_range(0, 3) != 0)
            add_read(hit_cells[$urandom_range(0, hit_cells.size() - 1)]);
          else
            add_read(12'($urandom));
        end else begin
          k = $urandom_range(0, 7);
          add_point(pick_coord(xl, xh, ties), pick_coord(yl, yh, ties),
                    (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 : $urandom);
          if (cy > 0 && cy < 128)
            hit_cells.push_back(12'($urandom_range(0, 63) * ((cy > 64) ? 64 : cy)));
        end
      end
      drain();
    end

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
